/* hw/rtl/dbf_pkg.sv */
// Shared types and constants for the deblocking edge line filter.
// Used by dbf_strength, dbf_smooth and deblock_edge_line_filter_core; no dependencies.
package dbf_pkg;

    localparam int SAMPLE_W = 10;
    localparam int ALPHA_W  = 9;
    localparam int BETA_W   = 7;
    localparam int SUM_W    = 16;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [ALPHA_W-1:0]  alpha_t;
    typedef logic [BETA_W-1:0]   beta_t;
    typedef logic [SUM_W-1:0]    wsum_t;

    typedef struct packed {
        sample_t l2;
        sample_t l1;
        sample_t l0;
        sample_t r0;
        sample_t r1;
        sample_t r2;
    } line_t;

    typedef struct packed {
        line_t  px;
        alpha_t alpha;
        beta_t  beta;
        logic   chroma;
        logic   enable;
    } edge_item_t;

    typedef enum logic [2:0] {
        STR_NONE,
        STR_WEAK,
        STR_MID,
        STR_STRONG,
        STR_FULL
    } strength_t;

    function automatic sample_t abs_diff(input sample_t a, input sample_t b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* hw/rtl/dbf_strength.sv */
// Edge decision: measures side flatness and picks the filter strength for one line.
// Depends on dbf_pkg.
module dbf_strength (
    input  dbf_pkg::edge_item_t item,
    output dbf_pkg::strength_t  strength
);
    import dbf_pkg::*;

    sample_t   step;
    sample_t   beta_x;
    logic      active;
    logic      both_flat;
    logic [1:0] fl;
    logic [1:0] fr;
    logic [2:0] flat_sum;
    strength_t base;

    assign step   = abs_diff(item.px.r0, item.px.l0);
    assign beta_x = SAMPLE_W'(item.beta);
    assign active = item.enable && (step < SAMPLE_W'(item.alpha)) && (step > SAMPLE_W'(1));

    assign both_flat = (item.px.r1 == item.px.r0) && (item.px.l0 == item.px.l1);

    assign fl = {abs_diff(item.px.l1, item.px.l0) < beta_x,
                 abs_diff(item.px.l2, item.px.l0) < beta_x};
    assign fr = {abs_diff(item.px.r0, item.px.r1) < beta_x,
                 abs_diff(item.px.r0, item.px.r2) < beta_x};
    assign flat_sum = {1'b0, fl} + {1'b0, fr};

    always_comb
    begin
        case (flat_sum)
            3'd6:    base = both_flat ? STR_FULL : STR_STRONG;
            3'd5:    base = both_flat ? STR_STRONG : STR_MID;
            3'd4:    base = (fl == 2'd2) ? STR_MID : STR_WEAK;
            3'd3:    base = (abs_diff(item.px.l1, item.px.r1) < beta_x) ? STR_WEAK : STR_NONE;
            default: base = STR_NONE;
        endcase
    end

    always_comb
    begin
        if (!active)
        begin
            strength = STR_NONE;
        end
        else if (!item.chroma)
        begin
            strength = base;
        end
        else
        begin
            case (base)
                STR_FULL:   strength = STR_STRONG;
                STR_STRONG: strength = STR_MID;
                STR_MID:    strength = STR_WEAK;
                default:    strength = STR_NONE;
            endcase
        end
    end

endmodule

/* hw/rtl/dbf_smooth.sv */
// Sample smoothing: rounded weighted sums across the edge, selected by strength.
// Depends on dbf_pkg.
module dbf_smooth (
    input  dbf_pkg::line_t     px,
    input  dbf_pkg::strength_t strength,
    output dbf_pkg::line_t     result
);
    import dbf_pkg::*;

    wsum_t l2, l1, l0, r0, r1, r2;
    wsum_t f4_l0, f4_l1, f4_l2, f4_r0, f4_r1, f4_r2;
    wsum_t f3_l0, f3_l1, f3_r0, f3_r1;
    wsum_t f2_l0, f2_r0;
    wsum_t f1_l0, f1_r0;

    assign l2 = SUM_W'(px.l2);
    assign l1 = SUM_W'(px.l1);
    assign l0 = SUM_W'(px.l0);
    assign r0 = SUM_W'(px.r0);
    assign r1 = SUM_W'(px.r1);
    assign r2 = SUM_W'(px.r2);

    assign f4_l0 = 16'd9 * l0 + 16'd9 * l2 + 16'd8 * r0 + 16'd6 * r2 + 16'd16;
    assign f4_l1 = 16'd7 * l0 + 16'd6 * l2 + 16'd3 * r0 + 16'd8;
    assign f4_l2 = 16'd4 * l0 + 16'd3 * l2 + r0 + 16'd4;
    assign f4_r0 = 16'd9 * r0 + 16'd9 * r2 + 16'd8 * l0 + 16'd6 * l2 + 16'd16;
    assign f4_r1 = 16'd7 * r0 + 16'd6 * r2 + 16'd3 * l0 + 16'd8;
    assign f4_r2 = 16'd4 * r0 + 16'd3 * r2 + l0 + 16'd4;

    assign f3_l0 = l2 + 16'd4 * l1 + 16'd6 * l0 + 16'd4 * r0 + r1 + 16'd8;
    assign f3_r0 = l1 + 16'd4 * l0 + 16'd6 * r0 + 16'd4 * r1 + r2 + 16'd8;
    assign f3_l1 = 16'd3 * l2 + 16'd8 * l1 + 16'd4 * l0 + r0 + 16'd8;
    assign f3_r1 = 16'd3 * r2 + 16'd8 * r1 + 16'd4 * r0 + l0 + 16'd8;

    assign f2_l0 = 16'd3 * l1 + 16'd10 * l0 + 16'd3 * r0 + 16'd8;
    assign f2_r0 = 16'd3 * l0 + 16'd10 * r0 + 16'd3 * r1 + 16'd8;

    assign f1_l0 = 16'd3 * l0 + r0 + 16'd2;
    assign f1_r0 = 16'd3 * r0 + l0 + 16'd2;

    always_comb
    begin
        result = px;
        case (strength)
            STR_FULL:
            begin
                result.l0 = f4_l0[14:5];
                result.l1 = f4_l1[13:4];
                result.l2 = f4_l2[12:3];
                result.r0 = f4_r0[14:5];
                result.r1 = f4_r1[13:4];
                result.r2 = f4_r2[12:3];
            end
            STR_STRONG:
            begin
                result.l0 = f3_l0[13:4];
                result.r0 = f3_r0[13:4];
                result.l1 = f3_l1[13:4];
                result.r1 = f3_r1[13:4];
            end
            STR_MID:
            begin
                result.l0 = f2_l0[13:4];
                result.r0 = f2_r0[13:4];
            end
            STR_WEAK:
            begin
                result.l0 = f1_l0[11:2];
                result.r0 = f1_r0[11:2];
            end
            default:
            begin
                result = px;
            end
        endcase
    end

endmodule

/* hw/rtl/deblock_edge_line_filter_core.sv */
// Top level of the deblocking edge line filter: input register, decision, smoothing,
// result register.
// Depends on dbf_pkg, dbf_strength and dbf_smooth.
//
// Usage:
//   s_* channel takes one line of six samples across a block edge per transfer.
//     s_tdata carries the samples and the alpha and beta thresholds.
//     s_tuser carries the chroma and enable flags.
//   m_* channel gives the six filtered samples of that line, one transfer per line.
// Pipeline: a line passes the input register, then the result register, with the
//   strength decision and the weighted sums between them; m_tvalid rises once the
//   line is in the result register.
// Throughput: one line per cycle; lines are independent, so a new transfer is
//   taken every cycle while the output side accepts.
// Reset: rst_n clears both valid flags; the pipeline comes up empty.
// Stall: when m_tready is low a full result register holds, the input register
//   holds once full, and s_tready drops only when both stages hold data.
module deblock_edge_line_filter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // left_far, left_mid, left_near, right_near, right_mid, right_far, alpha_limit, beta_limit
    input  logic [dbf_pkg::S_TDATA_W-1:0] s_tdata,
    // is_chroma, edge_enable
    input  logic [dbf_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_left_far, out_left_mid, out_left_near, out_right_near, out_right_mid, out_right_far
    output logic [dbf_pkg::M_TDATA_W-1:0] m_tdata
);
    import dbf_pkg::*;

    edge_item_t in_item;
    edge_item_t in_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    line_t      out_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       advance;
    logic       s_fire;
    strength_t  strength;
    line_t      filtered;

    assign in_item.px.l2  = s_tdata[9:0];
    assign in_item.px.l1  = s_tdata[19:10];
    assign in_item.px.l0  = s_tdata[29:20];
    assign in_item.px.r0  = s_tdata[39:30];
    assign in_item.px.r1  = s_tdata[49:40];
    assign in_item.px.r2  = s_tdata[59:50];
    assign in_item.alpha  = s_tdata[68:60];
    assign in_item.beta   = s_tdata[75:69];
    assign in_item.chroma = s_tuser[0];
    assign in_item.enable = s_tuser[1];

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    dbf_strength u_strength (
        .item     (in_reg),
        .strength (strength)
    );

    dbf_smooth u_smooth (
        .px       (in_reg.px),
        .strength (strength),
        .result   (filtered)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_reg <= in_item;
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= filtered;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.r2, out_reg.r1, out_reg.r0,
                       out_reg.l0, out_reg.l1, out_reg.l2};

endmodule

/* tb/deblock_edge_line_filter_core_tb.sv */
// Self-checking testbench for deblock_edge_line_filter_core: directed edge cases, then random lines.
// Predicts each filtered line in-house or from the directed table; checks every m_* transfer in order.
// Depends on dbf_pkg and deblock_edge_line_filter_core.
module deblock_edge_line_filter_core_tb;

    import dbf_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_LINES  = 517;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRED         = -1;
    localparam int N_DIRECTED   = 24;

    typedef struct {
        sample_t lf;
        sample_t lm;
        sample_t ln;
        sample_t rn;
        sample_t rm;
        sample_t rf;
    } six_t;

    typedef struct {
        six_t   px;
        alpha_t alpha;
        beta_t  beta;
        logic   chroma;
        logic   enable;
    } line_item_t;

    // lf lm ln rn rm rf alpha beta chroma enable | expected lf..rf, PRED = use predictor
    localparam int DIRECTED [N_DIRECTED][16] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
          0, 0, 0, 0, 0, 0},
        '{1023, 1023, 1023, 1023, 1023, 1023, 511, 127, 1, 1,
          1023, 1023, 1023, 1023, 1023, 1023},
        '{100, 100, 100, 120, 120, 120, 256, 10, 0, 0,
          100, 100, 100, 120, 120, 120},
        '{100, 100, 100, 120, 120, 120, 0, 10, 0, 1,
          100, 100, 100, 120, 120, 120},
        '{100, 100, 100, 120, 120, 120, 256, 0, 0, 1,
          100, 100, 100, 120, 120, 120},
        '{100, 100, 100, 101, 101, 101, 256, 10, 0, 1,
          100, 100, 100, 101, 101, 101},
        '{100, 100, 100, 120, 120, 120, 256, 10, 0, 1,
          103, 104, 109, 111, 116, 118},
        '{100, 100, 100, 120, 120, 120, 256, 10, 1, 1,
          PRED, 0, 0, 0, 0, 0},
        '{100, 100, 100, 120, 120, 120, 20, 10, 0, 1,
          100, 100, 100, 120, 120, 120},
        '{100, 100, 100, 120, 120, 120, 21, 10, 0, 1,
          PRED, 0, 0, 0, 0, 0},
        '{50, 100, 100, 120, 120, 120, 256, 10, 0, 1,
          PRED, 0, 0, 0, 0, 0},
        '{100, 102, 100, 120, 121, 120, 256, 10, 0, 1,
          PRED, 0, 0, 0, 0, 0},
        '{50, 102, 100, 120, 121, 120, 256, 10, 0, 1,
          PRED, 0, 0, 0, 0, 0},
        '{50, 102, 100, 120, 121, 200, 256, 10, 0, 1,
          PRED, 0, 0, 0, 0, 0},
        '{100, 102, 100, 120, 200, 121, 256, 10, 0, 1,
          PRED, 0, 0, 0, 0, 0},
        '{0, 100, 100, 110, 90, 115, 256, 20, 0, 1,
          PRED, 0, 0, 0, 0, 0},
        '{0, 100, 100, 110, 90, 115, 256, 20, 1, 1,
          0, 100, 100, 110, 90, 115},
        '{0, 100, 100, 110, 200, 115, 256, 20, 0, 1,
          0, 100, 100, 110, 200, 115},
        '{1023, 1023, 1023, 1021, 1021, 1021, 3, 1, 0, 1,
          PRED, 0, 0, 0, 0, 0},
        '{0, 0, 0, 2, 2, 2, 3, 1, 0, 1,
          PRED, 0, 0, 0, 0, 0},
        '{0, 0, 0, 2, 2, 2, 3, 1, 1, 1,
          PRED, 0, 0, 0, 0, 0},
        '{100, 300, 100, 120, 300, 120, 256, 10, 0, 1,
          100, 300, 100, 120, 300, 120},
        '{1023, 0, 1023, 0, 1023, 0, 511, 127, 1, 1,
          1023, 0, 1023, 0, 1023, 0},
        '{700, 700, 700, 900, 900, 900, 300, 100, 0, 1,
          PRED, 0, 0, 0, 0, 0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    six_t        expected_lines[$];
    six_t        want_line;
    six_t        got_line;
    int          mismatches = 0;
    int          lines_checked = 0;
    int          lines_sent = 0;
    int          quiet_cycles = 0;
    int          tx_idle_pct = 9;
    int          rx_idle_pct = 50;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          strength_hits[5] = '{0, 0, 0, 0, 0};

    deblock_edge_line_filter_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int unsigned mag_diff(input int unsigned a, input int unsigned b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic six_t deblock_line(input line_item_t it, output strength_t fs);
        six_t        o;
        int unsigned l2, l1, l0, r0, r1, r2;
        int unsigned edge_step, fl, fr;
        bit          both_flat;
        o = it.px;
        l2 = it.px.lf;
        l1 = it.px.lm;
        l0 = it.px.ln;
        r0 = it.px.rn;
        r1 = it.px.rm;
        r2 = it.px.rf;
        fs = STR_NONE;
        edge_step = mag_diff(r0, l0);
        if (it.enable && edge_step < it.alpha && edge_step > 1)
        begin
            fl = (mag_diff(l1, l0) < it.beta) ? 2 : 0;
            fr = (mag_diff(r0, r1) < it.beta) ? 2 : 0;
            if (mag_diff(l2, l0) < it.beta) fl += 1;
            if (mag_diff(r0, r2) < it.beta) fr += 1;
            both_flat = (r1 == r0) && (l0 == l1);
            case (fl + fr)
                6:       fs = both_flat ? STR_FULL : STR_STRONG;
                5:       fs = both_flat ? STR_STRONG : STR_MID;
                4:       fs = (fl == 2) ? STR_MID : STR_WEAK;
                3:       fs = (mag_diff(l1, r1) < it.beta) ? STR_WEAK : STR_NONE;
                default: fs = STR_NONE;
            endcase
            if (it.chroma && fs != STR_NONE) fs = strength_t'(fs - 1);
            case (fs)
                STR_FULL:
                begin
                    o.ln = sample_t'((9 * l0 + 9 * l2 + 8 * r0 + 6 * r2 + 16) >> 5);
                    o.lm = sample_t'((7 * l0 + 6 * l2 + 3 * r0 + 8) >> 4);
                    o.lf = sample_t'((4 * l0 + 3 * l2 + r0 + 4) >> 3);
                    o.rn = sample_t'((9 * r0 + 9 * r2 + 8 * l0 + 6 * l2 + 16) >> 5);
                    o.rm = sample_t'((7 * r0 + 6 * r2 + 3 * l0 + 8) >> 4);
                    o.rf = sample_t'((4 * r0 + 3 * r2 + l0 + 4) >> 3);
                end
                STR_STRONG:
                begin
                    o.ln = sample_t'((l2 + 4 * l1 + 6 * l0 + 4 * r0 + r1 + 8) >> 4);
                    o.rn = sample_t'((l1 + 4 * l0 + 6 * r0 + 4 * r1 + r2 + 8) >> 4);
                    o.lm = sample_t'((3 * l2 + 8 * l1 + 4 * l0 + r0 + 8) >> 4);
                    o.rm = sample_t'((3 * r2 + 8 * r1 + 4 * r0 + l0 + 8) >> 4);
                end
                STR_MID:
                begin
                    o.ln = sample_t'((3 * l1 + 10 * l0 + 3 * r0 + 8) >> 4);
                    o.rn = sample_t'((3 * l0 + 10 * r0 + 3 * r1 + 8) >> 4);
                end
                STR_WEAK:
                begin
                    o.ln = sample_t'((3 * l0 + r0 + 2) >> 2);
                    o.rn = sample_t'((3 * r0 + l0 + 2) >> 2);
                end
                default:
                begin
                end
            endcase
        end
        return o;
    endfunction

    function automatic sample_t near_sample(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return sample_t'(v);
    endfunction

    function automatic line_item_t random_line();
        line_item_t it;
        int         cl, cr, spread;
        if ($urandom_range(9) == 0)
        begin
            it.px.lf = sample_t'($urandom_range(0, 1023));
            it.px.lm = sample_t'($urandom_range(0, 1023));
            it.px.ln = sample_t'($urandom_range(0, 1023));
            it.px.rn = sample_t'($urandom_range(0, 1023));
            it.px.rm = sample_t'($urandom_range(0, 1023));
            it.px.rf = sample_t'($urandom_range(0, 1023));
            it.alpha = alpha_t'($urandom_range(0, 511));
            it.beta  = beta_t'($urandom_range(0, 127));
        end
        else
        begin
            spread = ($urandom_range(3) == 0) ? int'($urandom_range(0, 30))
                                              : int'($urandom_range(0, 3));
            cl = int'($urandom_range(0, 1023));
            cr = cl + int'($urandom_range(0, 80)) - 40;
            it.px.lf = near_sample(cl, spread);
            it.px.lm = near_sample(cl, spread);
            it.px.ln = near_sample(cl, spread);
            it.px.rn = near_sample(cr, spread);
            it.px.rm = near_sample(cr, spread);
            it.px.rf = near_sample(cr, spread);
            it.alpha = alpha_t'($urandom_range(0, 256));
            it.beta  = beta_t'($urandom_range(0, 108));
        end
        it.chroma = 1'($urandom_range(1));
        it.enable = ($urandom_range(9) != 0);
        return it;
    endfunction

    task automatic offer_line(input line_item_t it, input six_t want);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, it.beta, it.alpha, it.px.rf, it.px.rm, it.px.rn,
                     it.px.ln, it.px.lm, it.px.lf};
        s_tuser  <= {it.enable, it.chroma};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_lines.push_back(want);
        lines_sent++;
    endtask

    task automatic check_sample(input string what, input sample_t want, input sample_t got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // receiver: random stalls, plus one long hold-off to back up the pipeline
    always @(posedge clk)
    begin
        if (!hold_done && lines_checked >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_line.lf = m_tdata[9:0];
            got_line.lm = m_tdata[19:10];
            got_line.ln = m_tdata[29:20];
            got_line.rn = m_tdata[39:30];
            got_line.rm = m_tdata[49:40];
            got_line.rf = m_tdata[59:50];
            if (expected_lines.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected transfer, expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want_line = expected_lines.pop_front();
                check_sample("out_left_far",   want_line.lf, got_line.lf);
                check_sample("out_left_mid",   want_line.lm, got_line.lm);
                check_sample("out_left_near",  want_line.ln, got_line.ln);
                check_sample("out_right_near", want_line.rn, got_line.rn);
                check_sample("out_right_mid",  want_line.rm, got_line.rm);
                check_sample("out_right_far",  want_line.rf, got_line.rf);
            end
            lines_checked <= lines_checked + 1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t: no transfer for %0d cycles, %0d lines outstanding",
                 $time, STALL_LIMIT, expected_lines.size());
        $display("deblock_edge_line_filter_core regression: fail");
        $finish;
    end

    initial
    begin
        line_item_t it;
        six_t       want;
        strength_t  fs;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            it.px.lf  = sample_t'(DIRECTED[r][0]);
            it.px.lm  = sample_t'(DIRECTED[r][1]);
            it.px.ln  = sample_t'(DIRECTED[r][2]);
            it.px.rn  = sample_t'(DIRECTED[r][3]);
            it.px.rm  = sample_t'(DIRECTED[r][4]);
            it.px.rf  = sample_t'(DIRECTED[r][5]);
            it.alpha  = alpha_t'(DIRECTED[r][6]);
            it.beta   = beta_t'(DIRECTED[r][7]);
            it.chroma = 1'(DIRECTED[r][8]);
            it.enable = 1'(DIRECTED[r][9]);
            want = deblock_line(it, fs);
            strength_hits[fs]++;
            if (DIRECTED[r][10] != PRED)
            begin
                want.lf = sample_t'(DIRECTED[r][10]);
                want.lm = sample_t'(DIRECTED[r][11]);
                want.ln = sample_t'(DIRECTED[r][12]);
                want.rn = sample_t'(DIRECTED[r][13]);
                want.rm = sample_t'(DIRECTED[r][14]);
                want.rf = sample_t'(DIRECTED[r][15]);
            end
            offer_line(it, want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 50 : 0;
            rx_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 9 : 0;
            for (int n = 0; n < PHASE_LINES; n++)
            begin
                it = random_line();
                want = deblock_line(it, fs);
                strength_hits[fs]++;
                offer_line(it, want);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_lines.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d lines, checked %0d with %0d mismatches, long output hold-off %0s.",
                 lines_sent, lines_checked, mismatches, hold_done ? "seen" : "missed");
        $display("Strength mix none/weak/mid/strong/full: %0d/%0d/%0d/%0d/%0d.",
                 strength_hits[STR_NONE], strength_hits[STR_WEAK], strength_hits[STR_MID],
                 strength_hits[STR_STRONG], strength_hits[STR_FULL]);
        if (mismatches == 0)
            $display("deblock_edge_line_filter_core regression: pass");
        else
            $display("deblock_edge_line_filter_core regression: fail");
        $finish;
    end

endmodule
